FILE: sv/bcba_pkg.sv
// Shared types, constants and state encodings of the bitmap block allocator.
package bcba_pkg;

  localparam int unsigned MaxBlocksDflt = 256;
  localparam int unsigned BlkCntW       = 13;
  localparam int unsigned SizeW         = 13;
  localparam int unsigned CountW        = 9;
  localparam int unsigned BytesW        = 21;
  localparam int unsigned OffsW         = 20;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 13;
  localparam int unsigned MaxSize       = 4096;
  localparam int unsigned SizeRst       = 64;
  localparam int unsigned CountRst      = 256;
  localparam int unsigned DivSteps      = BytesW;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_COUNT = 2'd1;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_REPLY
  } cmd_op_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_MARK,
    BK_REPLY
  } back_state_e;

  typedef struct packed {
    kind_e               kind;
    logic [BytesW-1:0]   byte_count;
    logic [OffsW-1:0]    release_offset;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [OffsW-1:0]    granted_offset;
  } res_t;

  typedef struct packed {
    cmd_op_e             op;
    status_e             status;
    logic [BlkCntW-1:0]  n;
    logic [BlkCntW-1:0]  first;
  } cmd_t;

  typedef struct packed {
    logic [SizeW-1:0]    size;
    logic [BlkCntW-1:0]  count;
  } cfg_t;

endpackage

FILE: sv/bcba_fifo.sv
// Small synchronous queue used for the allocator's command and result queues.
module bcba_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = bcba_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  import bcba_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NumW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [NumW-1:0]  num_q, num_d;
  logic             do_push, do_pop;

  assign full_o  = (num_q == NumW'(DEPTH));
  assign empty_o = (num_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    num_d    = num_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      num_d = num_q + 1'b1;
    end else if (do_pop && !do_push) begin
      num_d = num_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      num_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      num_q    <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/bcba_front.sv
// Front stage: accept requests, convert bytes and offsets to blocks, classify.
module bcba_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bcba_pkg::cfg_t  cfg_i,
  input  logic            hold_i,
  input  logic            push_i,
  input  bcba_pkg::req_t  req_i,
  output logic            full_o,
  output logic            cmd_push_o,
  output bcba_pkg::cmd_t  cmd_o,
  input  logic            cmd_full_i
);
  import bcba_pkg::*;

  localparam int unsigned CntW = $clog2(DivSteps);
  localparam int unsigned WideW = BytesW + 1;

  front_state_e        state_q, state_d;
  req_t                req_q, req_d;
  logic [BytesW-1:0]   a_q, a_d;
  logic [BytesW-1:0]   b_q, b_d;
  logic [SizeW-1:0]    ra_q, ra_d;
  logic [SizeW-1:0]    rb_q, rb_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SizeW:0]      dvs, ta, tb;
  logic                ge_a, ge_b;
  logic [BytesW-1:0]   n_blk;
  logic [WideW-1:0]    n_w, cnt_w, first_w;

  assign full_o = (state_q != FR_IDLE) || hold_i;
  assign dvs    = {1'b0, cfg_i.size};
  assign ta     = {ra_q, a_q[BytesW-1]};
  assign tb     = {rb_q, b_q[BytesW-1]};
  assign ge_a   = (ta >= dvs);
  assign ge_b   = (tb >= dvs);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    a_d        = a_q;
    b_d        = b_q;
    ra_d       = ra_q;
    rb_d       = rb_q;
    cnt_d      = cnt_q;
    cmd_push_o = 1'b0;
    case (state_q)
      FR_IDLE: begin
        if (push_i && !full_o) begin
          req_d   = req_i;
          a_d     = req_i.byte_count - 1'b1;
          b_d     = BytesW'(req_i.release_offset);
          ra_d    = '0;
          rb_d    = '0;
          cnt_d   = '0;
          state_d = FR_DIV;
        end
      end
      FR_DIV: begin
        a_d   = {a_q[BytesW-2:0], ge_a};
        b_d   = {b_q[BytesW-2:0], ge_b};
        ra_d  = ge_a ? SizeW'(ta - dvs) : ta[SizeW-1:0];
        rb_d  = ge_b ? SizeW'(tb - dvs) : tb[SizeW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!cmd_full_i) begin
          cmd_push_o = 1'b1;
          state_d    = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  assign n_blk   = a_q + 1'b1;
  assign n_w     = WideW'(n_blk);
  assign cnt_w   = WideW'(cfg_i.count);
  assign first_w = WideW'(b_q);

  always_comb begin
    cmd_o.op     = CMD_REPLY;
    cmd_o.status = ST_BAD;
    cmd_o.n      = BlkCntW'(n_blk);
    cmd_o.first  = BlkCntW'(b_q);
    if (req_q.byte_count == '0) begin
      cmd_o.status = ST_BAD;
    end else if (req_q.kind == KIND_ALLOC) begin
      if (n_w > cnt_w) begin
        cmd_o.status = ST_NO_SPACE;
      end else begin
        cmd_o.op     = CMD_ALLOC;
        cmd_o.status = ST_OK;
      end
    end else begin
      if ((first_w >= cnt_w) || (n_w > (cnt_w - first_w))) begin
        cmd_o.status = ST_BAD;
      end else begin
        cmd_o.op     = CMD_FREE;
        cmd_o.status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    a_q   <= a_d;
    b_q   <= b_d;
    ra_q  <= ra_d;
    rb_q  <= rb_d;
  end

endmodule

FILE: sv/bcba_back.sv
// Back stage: usage map memory, first-fit scan, run marking and result build.
module bcba_back #(
  parameter int unsigned MAX_BLOCKS = bcba_pkg::MaxBlocksDflt
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bcba_pkg::cfg_t  cfg_i,
  output logic            clearing_o,
  input  bcba_pkg::cmd_t  cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  output logic            res_push_o,
  output bcba_pkg::res_t  res_o,
  input  logic            res_full_i
);
  import bcba_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned PW = AW + SizeW;

  logic map_mem [MAX_BLOCKS];

  back_state_e         state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  res_t                res_q, res_d;
  logic [AW:0]         iss_q, iss_d;
  logic [AW-1:0]       chk_q, chk_d;
  logic                chk_vld_q, chk_vld_d;
  logic [BlkCntW-1:0]  run_q, run_d;
  logic [AW-1:0]       mark_q, mark_d;
  logic [AW-1:0]       base_q, base_d;
  logic [BlkCntW-1:0]  left_q, left_d;
  logic                wval_q, wval_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic                rd_q;
  logic [AW-1:0]       raddr, waddr;
  logic                we, wdata;
  logic                issuing, hit, last;
  logic [BlkCntW-1:0]  run_inc;
  logic [PW-1:0]       prod;

  assign clearing_o = (state_q == BK_CLEAR);
  assign res_o      = res_q;
  assign raddr      = iss_q[AW-1:0];
  assign issuing    = (state_q == BK_SCAN) && (BlkCntW'(iss_q) < cfg_i.count);
  assign run_inc    = run_q + 1'b1;
  assign hit        = chk_vld_q && !rd_q && (run_inc >= cmd_q.n);
  assign last       = chk_vld_q && (BlkCntW'(chk_q) == (cfg_i.count - 1'b1));
  assign prod       = PW'(base_q) * PW'(cfg_i.size);
  assign we         = (state_q == BK_CLEAR) || (state_q == BK_MARK);
  assign waddr      = (state_q == BK_CLEAR) ? clr_q : mark_q;
  assign wdata      = (state_q == BK_CLEAR) ? 1'b0 : wval_q;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    iss_d      = iss_q;
    chk_d      = chk_q;
    chk_vld_d  = 1'b0;
    run_d      = run_q;
    mark_d     = mark_q;
    base_d     = base_q;
    left_d     = left_q;
    wval_d     = wval_q;
    clr_d      = clr_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(MAX_BLOCKS - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.op)
            CMD_ALLOC: begin
              iss_d   = '0;
              run_d   = '0;
              state_d = BK_SCAN;
            end
            CMD_FREE: begin
              mark_d  = AW'(cmd_i.first);
              base_d  = AW'(cmd_i.first);
              left_d  = cmd_i.n;
              wval_d  = 1'b0;
              state_d = BK_MARK;
            end
            default: begin
              res_d.status         = cmd_i.status;
              res_d.granted_offset = '0;
              state_d              = BK_REPLY;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (issuing) begin
          iss_d     = iss_q + 1'b1;
          chk_d     = iss_q[AW-1:0];
          chk_vld_d = 1'b1;
        end
        if (chk_vld_q) begin
          run_d = rd_q ? '0 : run_inc;
        end
        if (hit) begin
          mark_d    = AW'(BlkCntW'(chk_q) + 1'b1 - cmd_q.n);
          base_d    = AW'(BlkCntW'(chk_q) + 1'b1 - cmd_q.n);
          left_d    = cmd_q.n;
          wval_d    = 1'b1;
          run_d     = '0;
          chk_vld_d = 1'b0;
          state_d   = BK_MARK;
        end else if (last) begin
          res_d.status         = ST_NO_SPACE;
          res_d.granted_offset = '0;
          chk_vld_d            = 1'b0;
          state_d              = BK_REPLY;
        end
      end
      BK_MARK: begin
        mark_d = mark_q + 1'b1;
        left_d = left_q - 1'b1;
        if (left_q == BlkCntW'(1)) begin
          res_d.status         = ST_OK;
          res_d.granted_offset = wval_q ? OffsW'(prod) : '0;
          state_d              = BK_REPLY;
        end
      end
      BK_REPLY: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_q     <= '0;
      chk_vld_q <= 1'b0;
      iss_q     <= '0;
      run_q     <= '0;
      left_q    <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      chk_vld_q <= chk_vld_d;
      iss_q     <= iss_d;
      run_q     <= run_d;
      left_q    <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    res_q  <= res_d;
    chk_q  <= chk_d;
    mark_q <= mark_d;
    base_q <= base_d;
    wval_q <= wval_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      map_mem[waddr] <= wdata;
    end
    rd_q <= map_mem[raddr];
  end

  a_clear_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CLEAR) |-> !cmd_pop_o)
    else $error("command taken during map clear");

  a_mark_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MARK) |-> (BlkCntW'(mark_q) < cfg_i.count))
    else $error("run marking beyond managed blocks");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN) |-> (run_q < cmd_q.n))
    else $error("free run length passed request size");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

endmodule

FILE: sv/bitmap_contiguous_block_allocator.sv
// Top level of the bitmap first-fit block allocator: configuration and queues.
// Requests enter through a queue-style port (push/full) and results leave
// through one (empty/pop), one result per request, in request order. The
// front stage converts the byte count and release offset to blocks with a
// bit-serial divider and classifies it; a two-entry command queue feeds
// the back stage, which holds the usage map in a single-bit memory. An
// allocate scans the map one block a cycle from block 0 and then marks
// its run one block a cycle; a free marks its run one block a cycle; a
// rejected request goes straight to its reply. After reset the map is
// cleared one block a cycle, with full held high; configuration writes are
// taken at any time and cfg_ready_o is always high.
module bitmap_contiguous_block_allocator #(
  parameter int unsigned MAX_BLOCKS = bcba_pkg::MaxBlocksDflt
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bcba_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bcba_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  bcba_pkg::req_t                  req_i,
  output logic                            empty,
  input  logic                            pop,
  output bcba_pkg::res_t                  res_o
);
  import bcba_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(res_t);

  logic [SizeW-1:0]  block_size_q, block_size_d;
  logic [CountW-1:0] block_count_q, block_count_d;
  cfg_t              cfg;
  logic              clearing;
  logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t              cmd_in, cmd_out;
  logic [CmdW-1:0]   cmd_rdata;
  logic              res_push, res_full;
  res_t              res_in;
  logic [ResW-1:0]   res_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    block_size_d  = block_size_q;
    block_count_d = block_count_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BLOCK_SIZE:  block_size_d  = cfg_data_i[SizeW-1:0];
        CFG_BLOCK_COUNT: block_count_d = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= SizeW'(SizeRst);
      block_count_q <= CountW'(CountRst);
    end else begin
      block_size_q  <= block_size_d;
      block_count_q <= block_count_d;
    end
  end

  always_comb begin
    if (block_size_q == '0) begin
      cfg.size = SizeW'(1);
    end else if (block_size_q > SizeW'(MaxSize)) begin
      cfg.size = SizeW'(MaxSize);
    end else begin
      cfg.size = block_size_q;
    end
    if (BlkCntW'(block_count_q) > BlkCntW'(MAX_BLOCKS)) begin
      cfg.count = BlkCntW'(MAX_BLOCKS);
    end else begin
      cfg.count = BlkCntW'(block_count_q);
    end
  end

  bcba_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .hold_i     (clearing),
    .push_i     (push),
    .req_i      (req_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  bcba_fifo #(
    .WIDTH (CmdW),
    .DEPTH (QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_rdata);

  bcba_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .clearing_o  (clearing),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  bcba_fifo #(
    .WIDTH (ResW),
    .DEPTH (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_o = res_t'(res_rdata);

endmodule
